FILE: hdl/wcss_pkg.sv
// ----------------------------------------------------------------------------
// wcss_pkg
// shared types and constants of the windowed contingency skill score unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wcss_pkg;

  localparam int unsigned COUNT_WIDTH_DEF   = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // job payload counts are carried at the widest supported count width
  localparam int unsigned CNT_MAX_W   = 48;
  localparam int unsigned VAL_W       = 48;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [VAL_W-1:0] VAL_MAX      = 48'h7FFF_FFFF_FFFF;
  localparam int unsigned      NO_SCORE_MAG = 1000;

  localparam logic KIND_ACCUM  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // product order inside the score engine
  localparam logic [2:0] PR_HN  = 3'd0;
  localparam logic [2:0] PR_MF  = 3'd1;
  localparam logic [2:0] PR_MM  = 3'd2;
  localparam logic [2:0] PR_FF  = 3'd3;
  localparam logic [2:0] PR_SUM = 3'd4;

  // score order
  localparam logic [2:0] SC_POD    = 3'd0;
  localparam logic [2:0] SC_FAR    = 3'd1;
  localparam logic [2:0] SC_CSI    = 3'd2;
  localparam logic [2:0] SC_HSS    = 3'd3;
  localparam logic [2:0] SC_POD_NO = 3'd4;
  localparam logic [2:0] SC_BIAS   = 3'd5;

  // count slots
  localparam int unsigned C_NON = 0;
  localparam int unsigned C_MIS = 1;
  localparam int unsigned C_FAL = 2;
  localparam int unsigned C_HIT = 3;

  typedef enum logic [0:0] {
    CFG_OUTPUT_INTERVAL = 1'b0,
    CFG_START_TIME      = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PART_WIN_COUNTS = 2'd0,
    PART_WIN_SCORES = 2'd1,
    PART_TOT_COUNTS = 2'd2,
    PART_TOT_SCORES = 2'd3
  } part_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_FLUSH,
    F_DIV,
    F_APPLY,
    F_FIN_WIN,
    F_FIN_TOT
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CNT,
    B_MUL_LD,
    B_MUL_RUN,
    B_MUL_ACC,
    B_HSS,
    B_DIV_LD,
    B_DIV_RUN,
    B_DIV_END,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic        kind;
    logic [23:0] count_non;
    logic [23:0] count_miss;
    logic [23:0] count_false_alarm;
    logic [23:0] count_hit;
    logic [31:0] truth_stamp;
  } in_item_t;

  typedef struct packed {
    part_e                    part;
    logic                     last;
    logic [31:0]              window_end_offset;
    logic [31:0]              item_count;
    logic signed [VAL_W-1:0]  value_a;
    logic signed [VAL_W-1:0]  value_b;
    logic signed [VAL_W-1:0]  value_c;
    logic signed [VAL_W-1:0]  value_d;
    logic signed [VAL_W-1:0]  value_e;
    logic signed [VAL_W-1:0]  value_f;
  } res_t;

  typedef struct packed {
    logic                       is_total;
    logic                       last;
    logic [31:0]                offset;
    logic [31:0]                items;
    logic [3:0][CNT_MAX_W-1:0]  counts;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

`default_nettype wire

FILE: hdl/wcss_queue.sv
// ----------------------------------------------------------------------------
// wcss_queue
// short report job queue between the accumulator and the score engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcss_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wcss_pkg::push_t push_i,
  output      logic           full_o,
  output      logic           valid_o,
  output      wcss_pkg::job_t job_o,
  input  wire logic           pop_i
);

  localparam int unsigned DEPTH = wcss_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  wcss_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [AW:0]    cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      case ({push_i.valid, pop_i})
        2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> cnt_q < (AW+1)'(DEPTH))
    else $error("queue push while full");
`endif

endmodule

`default_nettype wire

FILE: hdl/wcss_front.sv
// ----------------------------------------------------------------------------
// wcss_front
// accepts items, keeps window and run sums, closes windows and queues reports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcss_front #(
  parameter int unsigned COUNT_WIDTH = wcss_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire wcss_pkg::in_item_t  in_data_i,
  input  wire logic                cfg_valid_i,
  input  wire wcss_pkg::cfg_reg_e  cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                queue_full_i,
  output      wcss_pkg::push_t     push_o
);

  localparam int unsigned SW = ((COUNT_WIDTH > 24) ? COUNT_WIDTH : 24) + 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [23:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    return (s > SW'(CMAX)) ? CMAX : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

  wcss_pkg::front_state_e state_q, state_d;
  logic [31:0] oi_q, oi_d, st_q, st_d, ws_q, ws_d;
  logic [3:0][COUNT_WIDTH-1:0] win_cnt_q, win_cnt_d, tot_cnt_q, tot_cnt_d;
  logic [31:0] win_items_q, win_items_d, tot_items_q, tot_items_d;
  logic [31:0] stamp_q, stamp_d;
  logic [3:0][23:0] add_q, add_d;
  logic [31:0] rem_q, rem_d, dvd_q, dvd_d;
  logic [4:0]  cnt_q, cnt_d;

  logic [31:0]      iv, diff_in, offset;
  logic             close_in, accept, do_add;
  logic [3:0][23:0] add_src, add_in;
  logic [32:0]      r;
  wcss_pkg::job_t   job;

  assign in_stall_o = (state_q != wcss_pkg::F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign iv         = (oi_q == 32'd0) ? 32'd1 : oi_q;
  assign diff_in    = in_data_i.truth_stamp - ws_q;
  assign close_in   = (in_data_i.truth_stamp > ws_q) && (diff_in > iv);
  assign offset     = ws_q + oi_q - st_q;
  assign r          = {rem_q, dvd_q[31]};

  assign add_in[wcss_pkg::C_NON] = in_data_i.count_non;
  assign add_in[wcss_pkg::C_MIS] = in_data_i.count_miss;
  assign add_in[wcss_pkg::C_FAL] = in_data_i.count_false_alarm;
  assign add_in[wcss_pkg::C_HIT] = in_data_i.count_hit;

  always_comb begin
    state_d     = state_q;
    oi_d        = oi_q;
    st_d        = st_q;
    ws_d        = ws_q;
    win_cnt_d   = win_cnt_q;
    tot_cnt_d   = tot_cnt_q;
    win_items_d = win_items_q;
    tot_items_d = tot_items_q;
    stamp_d     = stamp_q;
    add_d       = add_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    do_add      = 1'b0;
    add_src     = add_q;

    job.is_total = 1'b0;
    job.last     = 1'b0;
    job.offset   = offset;
    job.items    = win_items_q;
    for (int i = 0; i < 4; i++) begin
      job.counts[i] = wcss_pkg::CNT_MAX_W'(win_cnt_q[i]);
    end
    push_o.valid = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        wcss_pkg::CFG_OUTPUT_INTERVAL: oi_d = cfg_data_i;
        wcss_pkg::CFG_START_TIME: begin
          st_d = cfg_data_i;
          ws_d = cfg_data_i;
        end
        default: ;
      endcase
    end

    case (state_q)
      wcss_pkg::F_IDLE: begin
        if (accept) begin
          if (in_data_i.kind == wcss_pkg::KIND_FINISH) begin
            state_d = wcss_pkg::F_FIN_WIN;
          end else if (close_in) begin
            stamp_d = in_data_i.truth_stamp;
            add_d   = add_in;
            state_d = wcss_pkg::F_FLUSH;
          end else begin
            add_src = add_in;
            do_add  = 1'b1;
          end
        end
      end
      wcss_pkg::F_FLUSH: begin
        if (win_items_q == '0 || !queue_full_i) begin
          push_o.valid = (win_items_q != '0);
          job.last     = 1'b1;
          win_cnt_d    = '0;
          win_items_d  = '0;
          dvd_d        = stamp_q - ws_q - 32'd1;
          rem_d        = '0;
          cnt_d        = '0;
          state_d      = wcss_pkg::F_DIV;
        end
      end
      wcss_pkg::F_DIV: begin
        // remainder of (gap - 1) by the interval, one bit a cycle
        rem_d = (r >= {1'b0, iv}) ? 32'(r - {1'b0, iv}) : r[31:0];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = wcss_pkg::F_APPLY;
        end
      end
      wcss_pkg::F_APPLY: begin
        ws_d    = stamp_q - 32'd1 - rem_q;
        do_add  = 1'b1;
        state_d = wcss_pkg::F_IDLE;
      end
      wcss_pkg::F_FIN_WIN: begin
        if (win_items_q == '0) begin
          state_d = wcss_pkg::F_FIN_TOT;
        end else if (!queue_full_i) begin
          push_o.valid = 1'b1;
          state_d      = wcss_pkg::F_FIN_TOT;
        end
      end
      wcss_pkg::F_FIN_TOT: begin
        job.is_total = 1'b1;
        job.last     = 1'b1;
        job.items    = tot_items_q;
        for (int i = 0; i < 4; i++) begin
          job.counts[i] = wcss_pkg::CNT_MAX_W'(tot_cnt_q[i]);
        end
        if (!queue_full_i) begin
          push_o.valid = 1'b1;
          win_cnt_d    = '0;
          tot_cnt_d    = '0;
          win_items_d  = '0;
          tot_items_d  = '0;
          ws_d         = st_q;
          state_d      = wcss_pkg::F_IDLE;
        end
      end
      default: state_d = wcss_pkg::F_IDLE;
    endcase

    if (do_add) begin
      for (int i = 0; i < 4; i++) begin
        win_cnt_d[i] = sat_add(win_cnt_d[i], add_src[i]);
        tot_cnt_d[i] = sat_add(tot_cnt_d[i], add_src[i]);
      end
      win_items_d = sat_inc(win_items_d);
      tot_items_d = sat_inc(tot_items_d);
    end

    push_o.job = job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wcss_pkg::F_IDLE;
      oi_q        <= 32'd3600;
      st_q        <= '0;
      ws_q        <= '0;
      win_cnt_q   <= '0;
      tot_cnt_q   <= '0;
      win_items_q <= '0;
      tot_items_q <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      oi_q        <= oi_d;
      st_q        <= st_d;
      ws_q        <= ws_d;
      win_cnt_q   <= win_cnt_d;
      tot_cnt_q   <= tot_cnt_d;
      win_items_q <= win_items_d;
      tot_items_q <= tot_items_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    add_q   <= add_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wcss_pkg::F_DIV |-> rem_q < iv)
    else $error("window step remainder out of range");

  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid && push_o.job.is_total |=> tot_items_q == '0 && win_items_q == '0)
    else $error("run sums not cleared after totals");

  a_finish_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.kind == wcss_pkg::KIND_FINISH |=> state_q == wcss_pkg::F_FIN_WIN)
    else $error("finish item not followed by flush");
`endif

endmodule

`default_nettype wire

FILE: hdl/wcss_back.sv
// ----------------------------------------------------------------------------
// wcss_back
// score engine: emits counts, computes six scores with a serial multiplier
// and a serial divider, emits scores
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcss_back #(
  parameter int unsigned COUNT_WIDTH   = wcss_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = wcss_pkg::FRACTION_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire wcss_pkg::job_t  job_i,
  output      logic            pop_o,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      wcss_pkg::res_t  out_data_o
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned OW   = CW + 1;
  localparam int unsigned PW   = 2 * OW;
  localparam int unsigned NW   = 2 * CW + 4;
  localparam int unsigned DW   = NW + FRACTION_BITS + 2;
  localparam int unsigned RW   = NW + 2;
  localparam int unsigned QX   = DW + 48;
  localparam int unsigned XW   = (OW > 48) ? OW : 48;
  localparam int unsigned MCW  = $clog2(OW);
  localparam int unsigned DCW  = $clog2(DW);
  localparam logic [47:0] VMAX = wcss_pkg::VAL_MAX;
  localparam logic [47:0] ZOZ  =
    48'(64'd0 - (64'(wcss_pkg::NO_SCORE_MAG) << FRACTION_BITS));

  function automatic logic [47:0] clamp47(input logic [OW-1:0] v);
    return (XW'(v) > XW'(VMAX)) ? VMAX : 48'(v);
  endfunction

  wcss_pkg::back_state_e state_q, state_d;
  wcss_pkg::job_t job_q, job_d;
  logic [PW-1:0]  acc_q, acc_d, mcand_q, mcand_d, p1_q, p1_d, p2_q, p2_d;
  logic [OW-1:0]  mplier_q, mplier_d;
  logic [MCW-1:0] mcnt_q, mcnt_d;
  logic [2:0]     pidx_q, pidx_d, sidx_q, sidx_d;
  logic [NW-1:0]  hd_q, hd_d, hn_q, hn_d;
  logic           neg_q, neg_d;
  logic [DW-1:0]  dvd_q, dvd_d, quo_q, quo_d;
  logic [RW-1:0]  dvs_q, dvs_d, rem_q, rem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [47:0]    score_q [6];
  logic [47:0]    score_d;
  logic           score_we;
  wcss_pkg::res_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [CW-1:0] n, m, f, h;
  logic [OW-1:0] opa, opb;
  logic [NW-1:0] sel_num, sel_den;
  logic [RW-1:0] r;
  logic [QX-1:0] qx;
  logic [47:0]   mag;
  logic          out_free, out_load, neg_s;

  assign n = job_q.counts[wcss_pkg::C_NON][CW-1:0];
  assign m = job_q.counts[wcss_pkg::C_MIS][CW-1:0];
  assign f = job_q.counts[wcss_pkg::C_FAL][CW-1:0];
  assign h = job_q.counts[wcss_pkg::C_HIT][CW-1:0];

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign r     = {rem_q[RW-2:0], dvd_q[DW-1]};
  assign qx    = QX'(quo_q);
  assign mag   = ((qx >> 47) != '0) ? VMAX : qx[47:0];
  assign neg_s = neg_q && (sidx_q == wcss_pkg::SC_HSS);

  always_comb begin
    case (pidx_q)
      wcss_pkg::PR_HN: begin opa = OW'(h); opb = OW'(n); end
      wcss_pkg::PR_MF: begin opa = OW'(m); opb = OW'(f); end
      wcss_pkg::PR_MM: begin opa = OW'(m); opb = OW'(m); end
      wcss_pkg::PR_FF: begin opa = OW'(f); opb = OW'(f); end
      wcss_pkg::PR_SUM: begin
        opa = OW'(m) + OW'(f);
        opb = OW'(h) + OW'(n);
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    case (sidx_q)
      wcss_pkg::SC_POD: begin
        sel_num = NW'(h);
        sel_den = NW'(h) + NW'(m);
      end
      wcss_pkg::SC_FAR: begin
        sel_num = NW'(f);
        sel_den = NW'(f) + NW'(h);
      end
      wcss_pkg::SC_CSI: begin
        sel_num = NW'(h);
        sel_den = NW'(f) + NW'(m) + NW'(h);
      end
      wcss_pkg::SC_HSS: begin
        sel_num = hn_q;
        sel_den = hd_q;
      end
      wcss_pkg::SC_POD_NO: begin
        sel_num = NW'(n);
        sel_den = NW'(n) + NW'(f);
      end
      wcss_pkg::SC_BIAS: begin
        sel_num = NW'(h) + NW'(f);
        sel_den = NW'(h) + NW'(m);
      end
      default: begin
        sel_num = '0;
        sel_den = '0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    mcnt_d   = mcnt_q;
    pidx_d   = pidx_q;
    sidx_d   = sidx_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    hd_d     = hd_q;
    hn_d     = hn_q;
    neg_d    = neg_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    score_d  = '0;
    score_we = 1'b0;
    pop_o    = 1'b0;
    out_load = 1'b0;
    out_d    = out_q;

    case (state_q)
      wcss_pkg::B_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          state_d = wcss_pkg::B_CNT;
        end
      end
      wcss_pkg::B_CNT: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_d.part              = job_q.is_total ? wcss_pkg::PART_TOT_COUNTS
                                                   : wcss_pkg::PART_WIN_COUNTS;
          out_d.last              = 1'b0;
          out_d.window_end_offset = job_q.offset;
          out_d.item_count        = job_q.items;
          out_d.value_a           = clamp47(OW'(n));
          out_d.value_b           = clamp47(OW'(m));
          out_d.value_c           = clamp47(OW'(f));
          out_d.value_d           = clamp47(OW'(h));
          out_d.value_e           = clamp47(OW'(h) + OW'(m));
          out_d.value_f           = clamp47(OW'(h) + OW'(f));
          pidx_d                  = wcss_pkg::PR_HN;
          state_d                 = wcss_pkg::B_MUL_LD;
        end
      end
      wcss_pkg::B_MUL_LD: begin
        acc_d    = '0;
        mcand_d  = PW'(opa);
        mplier_d = opb;
        mcnt_d   = '0;
        state_d  = wcss_pkg::B_MUL_RUN;
      end
      wcss_pkg::B_MUL_RUN: begin
        // shift and add, one multiplier bit a cycle
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        mcnt_d   = mcnt_q + MCW'(1);
        if (mcnt_q == MCW'(OW - 1)) begin
          state_d = wcss_pkg::B_MUL_ACC;
        end
      end
      wcss_pkg::B_MUL_ACC: begin
        case (pidx_q)
          wcss_pkg::PR_HN: begin
            p1_d = acc_q;
            hd_d = NW'(acc_q) << 1;
          end
          wcss_pkg::PR_MF: p2_d = acc_q;
          default:         hd_d = hd_q + NW'(acc_q);
        endcase
        pidx_d = pidx_q + 3'd1;
        if (pidx_q == wcss_pkg::PR_SUM) begin
          state_d = wcss_pkg::B_HSS;
        end else begin
          state_d = wcss_pkg::B_MUL_LD;
        end
      end
      wcss_pkg::B_HSS: begin
        // magnitude and sign of the hss numerator
        neg_d   = (p1_q < p2_q);
        hn_d    = (p1_q < p2_q) ? (NW'(p2_q - p1_q) << 1) : (NW'(p1_q - p2_q) << 1);
        sidx_d  = wcss_pkg::SC_POD;
        state_d = wcss_pkg::B_DIV_LD;
      end
      wcss_pkg::B_DIV_LD: begin
        if (sel_den == '0) begin
          score_we = 1'b1;
          if (sel_num == '0) begin
            score_d = ZOZ;
          end else begin
            score_d = neg_s ? (48'd0 - VMAX) : VMAX;
          end
          sidx_d = sidx_q + 3'd1;
          state_d = (sidx_q == wcss_pkg::SC_BIAS) ? wcss_pkg::B_OUT
                                                   : wcss_pkg::B_DIV_LD;
        end else begin
          // round half up: (num * 2^(fb+1) + den) / (2 * den)
          dvd_d   = (DW'(sel_num) << (FRACTION_BITS + 1)) + DW'(sel_den);
          dvs_d   = RW'(sel_den) << 1;
          rem_d   = '0;
          quo_d   = '0;
          dcnt_d  = '0;
          state_d = wcss_pkg::B_DIV_RUN;
        end
      end
      wcss_pkg::B_DIV_RUN: begin
        if (r >= dvs_q) begin
          rem_d = r - dvs_q;
          quo_d = {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_d = r;
          quo_d = {quo_q[DW-2:0], 1'b0};
        end
        dvd_d  = dvd_q << 1;
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(DW - 1)) begin
          state_d = wcss_pkg::B_DIV_END;
        end
      end
      wcss_pkg::B_DIV_END: begin
        score_we = 1'b1;
        score_d  = neg_s ? (48'd0 - mag) : mag;
        sidx_d   = sidx_q + 3'd1;
        state_d  = (sidx_q == wcss_pkg::SC_BIAS) ? wcss_pkg::B_OUT
                                                  : wcss_pkg::B_DIV_LD;
      end
      wcss_pkg::B_OUT: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_d.part              = job_q.is_total ? wcss_pkg::PART_TOT_SCORES
                                                   : wcss_pkg::PART_WIN_SCORES;
          out_d.last              = job_q.last;
          out_d.window_end_offset = job_q.offset;
          out_d.item_count        = job_q.items;
          out_d.value_a           = score_q[wcss_pkg::SC_POD];
          out_d.value_b           = score_q[wcss_pkg::SC_FAR];
          out_d.value_c           = score_q[wcss_pkg::SC_CSI];
          out_d.value_d           = score_q[wcss_pkg::SC_HSS];
          out_d.value_e           = score_q[wcss_pkg::SC_POD_NO];
          out_d.value_f           = score_q[wcss_pkg::SC_BIAS];
          state_d                 = wcss_pkg::B_IDLE;
        end
      end
      default: state_d = wcss_pkg::B_IDLE;
    endcase

    out_valid_d = (out_valid_q && out_stall_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wcss_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      pidx_q      <= '0;
      sidx_q      <= '0;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pidx_q      <= pidx_d;
      sidx_q      <= sidx_d;
      mcnt_q      <= mcnt_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    hd_q     <= hd_d;
    hn_q     <= hn_d;
    neg_q    <= neg_d;
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
    if (score_we) begin
      score_q[sidx_q] <= score_d;
    end
  end

`ifndef SYNTHESIS
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wcss_pkg::B_DIV_RUN |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  a_pop_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == wcss_pkg::B_CNT)
    else $error("job taken but counts stage not entered");
`endif

endmodule

`default_nettype wire

FILE: hdl/windowed_contingency_skill_scores_unit.sv
// front: an accumulate item inside the window is summed on acceptance; one that closes
//   a window goes through flush, a 32-step remainder unit for the window step and apply
// a closed window gives counts once the back has taken its job and the output is free,
//   then scores, computed by the bit-serial multiplier and divider in the back end
// reset: asynchronous active low; interval 3600, start time 0, all sums cleared
// ----------------------------------------------------------------------------
// windowed_contingency_skill_scores_unit
// windowed 2x2 contingency sums with pod, far, csi, hss, pod_no and bias reports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_contingency_skill_scores_unit #(
  parameter int unsigned COUNT_WIDTH   = wcss_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = wcss_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // item input transfer
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire wcss_pkg::in_item_t  in_data_i,
  // result output transfer
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      wcss_pkg::res_t      out_data_o,
  // register writes
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire wcss_pkg::cfg_reg_e  cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);

  wcss_pkg::push_t push;
  wcss_pkg::job_t  job;
  logic            queue_full, job_valid, pop;

  // registers are plain flops, a write always lands
  assign cfg_ready_o = 1'b1;

  // front end: sums, window closing and report job generation
  wcss_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  // jobs carry a snapshot of the sums so the front can keep accumulating
  wcss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (queue_full),
    .valid_o (job_valid),
    .job_o   (job),
    .pop_i   (pop)
  );

  // back end: counts result, then the six scores through shared serial units
  wcss_back #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
